### rtl/core/gssa_pkg.sv
// ----------------------------------------------------------------------------
// gssa_pkg
// Shared types and constants for the generation slot stage/activate unit.
// ----------------------------------------------------------------------------
package gssa_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int GEN_W          = 32;
    localparam int HSLOT_W        = 3;

    typedef enum logic [1:0] {
        CMD_STAGE    = 2'd0,
        CMD_RELEASE  = 2'd1,
        CMD_ACTIVATE = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        RES_OK         = 2'd0,
        RES_FULL       = 2'd1,
        RES_BUILD_FAIL = 2'd2,
        RES_IGNORED    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [HSLOT_W-1:0] handle_slot;
        logic [GEN_W-1:0]   handle_generation;
        logic               compile_ok;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [HSLOT_W-1:0] out_slot;
        logic [GEN_W-1:0]   out_generation;
        logic               active_valid;
        logic [HSLOT_W-1:0] active_slot;
    } t_rsp;

endpackage

### rtl/core/gssa_pick.sv
// ----------------------------------------------------------------------------
// gssa_pick
// Priority pick of the lowest-numbered free slot.
// ----------------------------------------------------------------------------
module gssa_pick
    import gssa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic [SLOT_COUNT-1:0] i_free,
    output logic                  o_found,
    output logic [SW-1:0]         o_index
);

    always_comb begin
        o_found = |i_free;
        o_index = '0;
        // scan from the top so the lowest free slot wins
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (i_free[i]) begin
                o_index = SW'(i);
            end
        end
    end

endmodule

### rtl/core/gssa_gen_mem.sv
// ----------------------------------------------------------------------------
// gssa_gen_mem
// Per-slot generation store: one write port, one registered read port.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module gssa_gen_mem
    import gssa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int SW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_re,
    input  logic [SW-1:0]    i_raddr,
    input  logic             i_we,
    input  logic [SW-1:0]    i_waddr,
    input  logic [GEN_W-1:0] i_wdata,
    output logic [GEN_W-1:0] o_rdata
);

    logic [GEN_W-1:0]      r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_written;
    logic [GEN_W-1:0]      r_rdata;
    logic                  r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_ok <= r_written[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

### rtl/core/generation_slot_stage_activate_unit.sv
// ----------------------------------------------------------------------------
// generation_slot_stage_activate_unit
// Generational slot table: stage, release and activate commands.
// ----------------------------------------------------------------------------
//  channel   | signals                  | handshake
//  ----------+--------------------------+-------------------------------
//  request   | start, busy, i_req       | taken when start && !busy
//  result    | o_valid, o_rsp           | one-cycle strobe, no backpressure
//
// A request taken by the unit reads the generation memory; the execute state then
// compares, writes back and registers the result, so o_valid is high in the cycle
// after the execute state. busy is high for one cycle, in the execute state, so a
// new request is taken only after the last has executed its registered memory read.
// Reset (synchronous, active low) frees all slots and clears the active slot.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module generation_slot_stage_activate_unit
    import gssa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    t_state                r_state, n_state;
    t_req                  r_req;
    logic                  r_found;
    logic [SW-1:0]         r_pick;
    logic                  r_hok;
    logic [SLOT_COUNT-1:0] r_pend, n_pend;
    logic                  r_act_v, n_act_v;
    logic [SW-1:0]         r_act_idx, n_act_idx;
    logic                  r_valid;
    t_rsp                  r_rsp, n_rsp;

    logic                  accept;
    logic                  mem_we;
    logic [GEN_W-1:0]      mem_rdata;
    logic [GEN_W-1:0]      gen_inc;
    logic [SLOT_COUNT-1:0] free_vec;
    logic                  pick_found;
    logic [SW-1:0]         pick_index;
    logic [SW-1:0]         h_idx;
    logic                  match;

    assign accept = start && !busy;
    assign h_idx  = SW'(i_req.handle_slot);

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            free_vec[i] = !r_pend[i] && !(r_act_v && (r_act_idx == SW'(i)));
        end
    end

    gssa_pick #(
        .SLOT_COUNT(SLOT_COUNT),
        .SW        (SW)
    ) u_pick (
        .i_free (free_vec),
        .o_found(pick_found),
        .o_index(pick_index)
    );

    gssa_gen_mem #(
        .SLOT_COUNT(SLOT_COUNT),
        .SW        (SW)
    ) u_gen_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_re   (accept),
        .i_raddr((t_cmd'(i_req.cmd) == CMD_STAGE) ? pick_index : h_idx),
        .i_we   (mem_we),
        .i_waddr(r_pick),
        .i_wdata(gen_inc),
        .o_rdata(mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        unique case (r_state)
            S_IDLE:  busy = 1'b0;
            S_EXEC:  busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    // execute: compare against the read generation and update the table
    assign gen_inc = mem_rdata + GEN_W'(1);
    assign match   = r_hok && (mem_rdata == r_req.handle_generation)
                     && r_pend[SW'(r_req.handle_slot)];

    always_comb begin
        n_pend    = r_pend;
        n_act_v   = r_act_v;
        n_act_idx = r_act_idx;
        mem_we    = 1'b0;
        n_rsp     = '0;
        n_rsp.status = RES_IGNORED;
        if (r_state == S_EXEC) begin
            case (t_cmd'(r_req.cmd))
                CMD_STAGE: begin
                    if (!r_found) begin
                        n_rsp.status = RES_FULL;
                    end else if (!r_req.compile_ok) begin
                        n_rsp.status = RES_BUILD_FAIL;
                    end else begin
                        mem_we               = 1'b1;
                        n_pend[r_pick]       = 1'b1;
                        n_rsp.status         = RES_OK;
                        n_rsp.out_slot       = HSLOT_W'(r_pick);
                        n_rsp.out_generation = gen_inc;
                    end
                end
                CMD_RELEASE: begin
                    if (match) begin
                        n_pend[SW'(r_req.handle_slot)] = 1'b0;
                        n_rsp.status = RES_OK;
                    end
                end
                CMD_ACTIVATE: begin
                    // the previous active slot frees itself: it is not pending
                    if (match) begin
                        n_pend[SW'(r_req.handle_slot)] = 1'b0;
                        n_act_v      = 1'b1;
                        n_act_idx    = SW'(r_req.handle_slot);
                        n_rsp.status = RES_OK;
                    end
                end
                default: begin
                    n_rsp.status = RES_IGNORED;
                end
            endcase
        end
        n_rsp.active_valid = n_act_v;
        n_rsp.active_slot  = n_act_v ? HSLOT_W'(n_act_idx) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req   <= i_req;
            r_found <= pick_found;
            r_pick  <= pick_index;
            r_hok   <= (32'(i_req.handle_slot) < 32'(SLOT_COUNT));
        end
        if (r_state == S_EXEC) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= '0;
            r_act_v   <= 1'b0;
            r_act_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_act_v   <= n_act_v;
            r_act_idx <= n_act_idx;
            r_valid   <= (r_state == S_EXEC);
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTH
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_valid)
        else $error("execute cycle produced no result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result strobe without a request");

    a_active_not_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act_v |-> !r_pend[r_act_idx])
        else $error("active slot also marked pending");

    a_gen_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != RES_OK)) |-> (o_rsp.out_generation == '0))
        else $error("generation reported on a failed request");
`endif

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for generation_slot_stage_activate_unit. A behavioral
// slot table tracks slot states, generations and the active slot, and
// predicts every response. Each request sent through start/busy queues one
// expected response. A monitor compares each o_valid strobe, field by field,
// with the oldest entry in that queue. Directed tests cover stage, full
// table, build failure, release, activate and the ignored cases. A random
// phase follows, in bursts; its release and activate requests mostly use live handles.
// ----------------------------------------------------------------------------
module tb
    import gssa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS      = SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_PENDING = 2'd1,
        SLOT_ACTIVE  = 2'd2
    } t_slot_state;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    generation_slot_stage_activate_unit #(
        .SLOT_COUNT(NUM_SLOTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Slot table as the bench sees it
    t_slot_state        slot_state_m [NUM_SLOTS];
    logic [GEN_W-1:0]   slot_gen_m   [NUM_SLOTS];
    logic [HSLOT_W-1:0] live_slot_m;
    logic               live_valid_m;

    t_rsp expected_rsp_q [$];
    int   error_count = 0;
    int   idle_cycles = 0;

    function automatic t_req make_req(t_cmd cmd, int slot, logic [GEN_W-1:0] gen,
                                      logic cok);
        t_req r;
        r.cmd               = cmd;
        r.handle_slot       = slot[HSLOT_W-1:0];
        r.handle_generation = gen;
        r.compile_ok        = cok;
        return r;
    endfunction

    function automatic bit handle_is_pending(logic [HSLOT_W-1:0] s, logic [GEN_W-1:0] g);
        return slot_state_m[s] == SLOT_PENDING && slot_gen_m[s] == g;
    endfunction

    // Applies one request to the bench's table and returns the response
    function automatic t_rsp apply_table_command(t_req r);
        t_rsp e;
        int   pick;
        e        = '0;
        e.status = RES_IGNORED;
        case (r.cmd)
            CMD_STAGE: begin
                pick = -1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (pick < 0 && slot_state_m[i] == SLOT_FREE) begin
                        pick = i;
                    end
                end
                // full check comes before the build result
                if (pick < 0) begin
                    e.status = RES_FULL;
                end else if (!r.compile_ok) begin
                    e.status = RES_BUILD_FAIL;
                end else begin
                    slot_gen_m[pick]   = slot_gen_m[pick] + 1'b1;
                    slot_state_m[pick] = SLOT_PENDING;
                    e.status           = RES_OK;
                    e.out_slot         = pick[HSLOT_W-1:0];
                    e.out_generation   = slot_gen_m[pick];
                end
            end
            CMD_RELEASE: begin
                if (handle_is_pending(r.handle_slot, r.handle_generation)) begin
                    slot_state_m[r.handle_slot] = SLOT_FREE;
                    e.status                    = RES_OK;
                end
            end
            CMD_ACTIVATE: begin
                if (handle_is_pending(r.handle_slot, r.handle_generation)) begin
                    if (live_valid_m) begin
                        slot_state_m[live_slot_m] = SLOT_FREE;
                    end
                    slot_state_m[r.handle_slot] = SLOT_ACTIVE;
                    live_slot_m                 = r.handle_slot;
                    live_valid_m                = 1'b1;
                    e.status                    = RES_OK;
                end
            end
            default: begin
            end
        endcase
        e.active_valid = live_valid_m;
        e.active_slot  = live_valid_m ? live_slot_m : '0;
        return e;
    endfunction

    // Mostly valid handles taken from the live table, the rest stale or noise
    function automatic t_req random_request();
        t_req r;
        int   kind;
        int   s;
        int   pending_slots [$];
        r.cmd               = CMD_STAGE;
        r.handle_slot       = HSLOT_W'($urandom);
        r.handle_generation = $urandom;
        r.compile_ok        = ($urandom_range(0, 9) != 0);
        kind                = $urandom_range(0, 99);
        if (kind < 40) begin
            r.cmd = CMD_STAGE;
        end else if (kind < 88) begin
            r.cmd = (kind < 62) ? CMD_RELEASE : CMD_ACTIVATE;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_state_m[i] == SLOT_PENDING) begin
                    pending_slots.push_back(i);
                end
            end
            if (pending_slots.size() > 0 && $urandom_range(0, 4) != 0) begin
                s                   = pending_slots[$urandom_range(0, pending_slots.size() - 1)];
                r.handle_slot       = s[HSLOT_W-1:0];
                r.handle_generation = slot_gen_m[s];
            end else if ($urandom_range(0, 1) != 0) begin
                // right generation, slot may be free, pending or active
                r.handle_generation = slot_gen_m[r.handle_slot];
            end else if ($urandom_range(0, 1) != 0) begin
                r.handle_generation = slot_gen_m[r.handle_slot] - 1'b1;
            end
        end else if (kind < 93) begin
            r.cmd = CMD_NONE;
        end else begin
            r.cmd = t_cmd'($urandom_range(0, 3));
        end
        return r;
    endfunction

    // Holds the request until the unit takes it, then queues its response
    task automatic issue_request(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        expected_rsp_q.push_back(apply_table_command(r));
    endtask

    task automatic pause_requests(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic test_stage_and_full();
        issue_request(make_req(CMD_STAGE, 0, '0, 1'b0));
        for (int i = 0; i < NUM_SLOTS; i++) begin
            issue_request(make_req(CMD_STAGE, 7, '1, 1'b1));
        end
        issue_request(make_req(CMD_STAGE, 0, '0, 1'b1));
        issue_request(make_req(CMD_STAGE, 0, '0, 1'b0));
    endtask

    task automatic test_release();
        issue_request(make_req(CMD_RELEASE, 7, 32'd1, 1'b0));
        issue_request(make_req(CMD_RELEASE, 7, 32'd1, 1'b1));
        issue_request(make_req(CMD_STAGE, 0, '0, 1'b1));
    endtask

    task automatic test_activate();
        issue_request(make_req(CMD_ACTIVATE, 0, 32'd1, 1'b0));
        issue_request(make_req(CMD_ACTIVATE, 1, 32'd1, 1'b0));
        issue_request(make_req(CMD_ACTIVATE, 1, 32'd1, 1'b0));
        issue_request(make_req(CMD_RELEASE, 1, 32'd1, 1'b0));
    endtask

    task automatic test_ignored_cases();
        issue_request(make_req(CMD_RELEASE, 2, 32'hFFFF_FFFF, 1'b1));
        issue_request(make_req(CMD_ACTIVATE, 3, 32'd0, 1'b1));
        issue_request(make_req(CMD_NONE, 7, 32'hFFFF_FFFF, 1'b1));
        issue_request(make_req(CMD_STAGE, 0, '0, 1'b1));
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
            for (int i = 0; i < burst && sent < n_items; i++) begin
                issue_request(random_request());
                sent++;
            end
            pause_requests(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
    endtask

    // Response monitor
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_valid) begin
            if (expected_rsp_q.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("%0t: response with nothing outstanding: %p", $realtime, o_rsp);
                end
                error_count++;
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                if (o_rsp.status !== exp_rsp.status
                        || o_rsp.out_slot !== exp_rsp.out_slot
                        || o_rsp.out_generation !== exp_rsp.out_generation
                        || o_rsp.active_valid !== exp_rsp.active_valid
                        || o_rsp.active_slot !== exp_rsp.active_slot) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, exp_rsp, o_rsp);
                    end
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no request taken and no response
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL generation_slot_stage_activate_unit");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_state_m[i] = SLOT_FREE;
            slot_gen_m[i]   = '0;
        end
        live_slot_m  = '0;
        live_valid_m = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stage_and_full();
        pause_requests($urandom_range(1, 4));
        test_release();
        test_activate();
        pause_requests($urandom_range(1, 4));
        test_ignored_cases();
        test_random_traffic(RANDOM_ITEMS);
        pause_requests(1);

        while (expected_rsp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (expected_rsp_q.size() != 0) begin
            $display("%0d responses never arrived", expected_rsp_q.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("PASS generation_slot_stage_activate_unit");
        end else begin
            $display("FAIL generation_slot_stage_activate_unit");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/gssa_pkg.sv
rtl/core/gssa_pick.sv
rtl/core/gssa_gen_mem.sv
rtl/core/generation_slot_stage_activate_unit.sv
sim/tb.sv
